>>> design/lpht_pkg.sv
package lpht_pkg;

    // table geometry; SLOTS is a power of two so the home slot is the low key bits
    localparam int SLOTS      = 256;
    localparam int VALUE_W    = 32;
    localparam int KEY_W      = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int LIVE_OUT_W = 9;

    typedef logic [IDX_W-1:0] idx_t;

    // request kinds; the fourth code is answered but changes nothing
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_LIVE    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_st_t;

    localparam logic RES_DONE = 1'b0;
    localparam logic RES_FULL = 1'b1;

    // one slot as read back from the store
    typedef struct packed {
        slot_st_t           st;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

    // write command to the store, one address, per-field enables
    typedef struct packed {
        logic               key_en;
        logic               val_en;
        logic               st_en;
        idx_t               addr;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        slot_st_t           st;
    } store_wr_t;

endpackage

>>> design/linear_probe_hash_table.sv
// Each accepted request word runs READ then EVAL once per slot probed, P = slots probed
// (1 to SLOTS), then FINISH; the unused mode code goes straight to FINISH. Each probe: one store read, one compare.
// The block takes no new request until the last one is done; s_tready stays low until
// the result is loaded into the output register, and a stalled result side holds the block there.
// Reset (rst_n, async, active low): all slots empty, live count zero, no result pending.
// Key and value memories are not cleared; per-slot valid bits make unmarked slots read empty.
module linear_probe_hash_table (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value_in
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] value_out, [40:32] live_count, [47:41] zero
    output logic [1:0]  m_tuser    // [0] found, [1] status
);
    import lpht_pkg::*;

    // sequencer: READ issues one store read, EVAL compares it and either steps on or ends
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic [1:0]         mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    idx_t               idx_reg;
    idx_t               probe_cnt_reg;
    logic               free_valid_reg;
    idx_t               free_idx_reg;
    logic [CNT_W-1:0]   count_reg;

    // result held until the output register is free
    logic               res_found_reg;
    logic [31:0]        res_value_reg;
    logic               res_status_reg;

    // output register
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [31:0]        out_value_reg;
    logic               out_status_reg;
    logic [8:0]         out_count_reg;

    slot_t              rd_slot;
    store_wr_t          wr;
    logic               rd_en;

    // probe evaluation
    logic               live_hit;
    logic               is_empty;
    logic               last_probe;
    logic               stop;
    logic               cand;
    logic               free_any;
    idx_t               free_at;
    idx_t               idx_step;
    logic               eval_found;
    logic [31:0]        eval_value;
    logic               eval_status;
    logic [CNT_W-1:0]   count_next;

    logic               accept;
    logic               out_free;

    lpht_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .wr      (wr),
        .rd_slot (rd_slot)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = (state_reg == S_READ);
    assign out_free = !out_valid_reg || m_tready;

    assign idx_step   = (idx_reg == IDX_W'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign live_hit   = (rd_slot.st == SLOT_LIVE) && (rd_slot.key == key_reg);
    assign is_empty   = (rd_slot.st == SLOT_EMPTY);
    assign last_probe = (probe_cnt_reg == IDX_W'(SLOTS - 1));
    assign stop       = live_hit || is_empty || last_probe;
    // first deleted slot on the path, else the empty one that ends it
    assign cand       = !free_valid_reg && (rd_slot.st != SLOT_LIVE);
    assign free_any   = free_valid_reg || cand;
    assign free_at    = free_valid_reg ? free_idx_reg : idx_reg;

    always_comb
    begin
        wr          = '0;
        eval_found  = 1'b0;
        eval_value  = '0;
        eval_status = RES_DONE;
        count_next  = count_reg;
        if (state_reg == S_EVAL && stop)
        begin
            unique case (mode_reg)
                MODE_INSERT:
                begin
                    if (live_hit)
                    begin
                        eval_found = 1'b1;
                        wr.val_en  = 1'b1;
                        wr.addr    = idx_reg;
                        wr.value   = value_reg;
                    end
                    else if (free_any)
                    begin
                        wr.key_en  = 1'b1;
                        wr.val_en  = 1'b1;
                        wr.st_en   = 1'b1;
                        wr.addr    = free_at;
                        wr.key     = key_reg;
                        wr.value   = value_reg;
                        wr.st      = SLOT_LIVE;
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else
                    begin
                        eval_status = RES_FULL;
                    end
                end
                MODE_LOOKUP:
                begin
                    if (live_hit)
                    begin
                        eval_found = 1'b1;
                        eval_value = 32'(rd_slot.value);
                    end
                end
                MODE_REMOVE:
                begin
                    if (live_hit)
                    begin
                        eval_found = 1'b1;
                        eval_value = 32'(rd_slot.value);
                        wr.st_en   = 1'b1;
                        wr.addr    = idx_reg;
                        wr.st      = SLOT_DELETED;
                        if (count_reg != '0)
                        begin
                            count_next = CNT_W'(count_reg - 1'b1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= '0;
            key_reg        <= '0;
            value_reg      <= '0;
            idx_reg        <= '0;
            probe_cnt_reg  <= '0;
            free_valid_reg <= 1'b0;
            free_idx_reg   <= '0;
            count_reg      <= '0;
            res_found_reg  <= 1'b0;
            res_value_reg  <= '0;
            res_status_reg <= RES_DONE;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= RES_DONE;
            out_count_reg  <= '0;
        end
        else
        begin
            // word taken; the finish state reloads the register itself
            if (out_valid_reg && m_tready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg       <= s_tuser;
                        key_reg        <= s_tdata[31:0];
                        value_reg      <= VALUE_W'(s_tdata[63:32]);
                        probe_cnt_reg  <= '0;
                        free_valid_reg <= 1'b0;
                        res_found_reg  <= 1'b0;
                        res_value_reg  <= '0;
                        res_status_reg <= RES_DONE;
                        // home slot: key mod SLOTS, the low key bits
                        idx_reg        <= s_tdata[IDX_W-1:0];
                        if (s_tuser != MODE_INSERT && s_tuser != MODE_LOOKUP
                            && s_tuser != MODE_REMOVE)
                        begin
                            // unused code: empty result, nothing touched
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (stop)
                    begin
                        res_found_reg  <= eval_found;
                        res_value_reg  <= eval_value;
                        res_status_reg <= eval_status;
                        count_reg      <= count_next;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        if (cand)
                        begin
                            free_valid_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                        idx_reg       <= idx_step;
                        probe_cnt_reg <= probe_cnt_reg + 1'b1;
                        state_reg     <= S_READ;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_found_reg  <= res_found_reg;
                        out_value_reg  <= res_value_reg;
                        out_status_reg <= res_status_reg;
                        out_count_reg  <= LIVE_OUT_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_count_reg, out_value_reg};
    assign m_tuser  = {out_status_reg, out_found_reg};

endmodule

>>> design/lpht_store.sv
module lpht_store (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  lpht_pkg::idx_t      rd_addr,
    input  lpht_pkg::store_wr_t wr,
    output lpht_pkg::slot_t     rd_slot
);
    import lpht_pkg::*;

    logic [KEY_W-1:0]   key_mem [SLOTS];
    logic [VALUE_W-1:0] val_mem [SLOTS];
    slot_st_t           st_mem  [SLOTS];

    // per-slot valid bits: a slot never marked reads as empty
    logic [SLOTS-1:0]   valid_reg;
    logic               valid_rd_reg;

    logic [KEY_W-1:0]   key_rd_reg;
    logic [VALUE_W-1:0] val_rd_reg;
    slot_st_t           st_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.key_en)
        begin
            key_mem[wr.addr] <= wr.key;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.val_en)
        begin
            val_mem[wr.addr] <= wr.value;
        end
        if (rd_en)
        begin
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.st_en)
        begin
            st_mem[wr.addr] <= wr.st;
        end
        if (rd_en)
        begin
            st_rd_reg <= st_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.st_en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_rd_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_slot.st    = valid_rd_reg ? st_rd_reg : SLOT_EMPTY;
    assign rd_slot.key   = key_rd_reg;
    assign rd_slot.value = val_rd_reg;

endmodule

>>> sim/tb_linear_probe_hash_table.sv
module tb_linear_probe_hash_table;

    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    // fourth request code: the block answers it but leaves the table alone
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int HOLD_CYCLES    = 400;   // long result-side hold-off
    localparam int DRAIN_CYCLES   = 600;   // longer than the worst single request
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0]         mode;
        logic [KEY_W-1:0]   key;
        logic [31:0]        value;
    } table_req_t;

    typedef struct packed {
        logic                  found;
        logic [31:0]           value;
        logic                  status;
        logic [LIVE_OUT_W-1:0] live;
    } table_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    // shadow of the table, updated as each request word is accepted
    logic [KEY_W-1:0]   shadow_key [SLOTS];
    logic [VALUE_W-1:0] shadow_val [SLOTS];
    slot_st_t           shadow_st  [SLOTS];
    int unsigned        shadow_live = 0;

    table_req_t   pending_q [$];    // words waiting for the request side
    table_reply_t reply_q [$];      // replies owed by the block, oldest first
    logic [KEY_W-1:0] known_keys [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_req_seq  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int quiet_cycles  = 0;

    linear_probe_hash_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_st[i] = SLOT_EMPTY;
        end
    end

    // Walk the probe path from key mod SLOTS, stop on the live key or an
    // empty slot; remember the first reusable slot seen on the way.
    function automatic table_reply_t table_apply(table_req_t req);
        table_reply_t rep;
        int unsigned  idx;
        int unsigned  free_idx;
        int unsigned  hit_idx;
        int unsigned  n;
        bit           stop;
        rep      = '0;
        hit_idx  = SLOTS;
        free_idx = SLOTS;
        stop     = 1'b0;
        n        = 0;
        if (req.mode != MODE_UNUSED)
        begin
            idx = req.key % SLOTS;
            while (!stop && n < SLOTS)
            begin
                if (shadow_st[idx] == SLOT_EMPTY)
                begin
                    if (free_idx == SLOTS)
                        free_idx = idx;
                    stop = 1'b1;
                end
                else if (shadow_st[idx] == SLOT_LIVE && shadow_key[idx] == req.key)
                begin
                    hit_idx = idx;
                    stop    = 1'b1;
                end
                else
                begin
                    if (shadow_st[idx] == SLOT_DELETED && free_idx == SLOTS)
                        free_idx = idx;
                    idx = (idx + 1) % SLOTS;
                    n++;
                end
            end
            if (req.mode == MODE_INSERT)
            begin
                if (hit_idx < SLOTS)
                begin
                    rep.found           = 1'b1;
                    shadow_val[hit_idx] = req.value;
                end
                else if (free_idx < SLOTS)
                begin
                    shadow_key[free_idx] = req.key;
                    shadow_val[free_idx] = req.value;
                    shadow_st[free_idx]  = SLOT_LIVE;
                    shadow_live++;
                end
                else
                begin
                    rep.status = RES_FULL;
                end
            end
            else if (hit_idx < SLOTS)
            begin
                rep.found = 1'b1;
                rep.value = shadow_val[hit_idx];
                if (req.mode == MODE_REMOVE)
                begin
                    shadow_st[hit_idx] = SLOT_DELETED;
                    if (shadow_live > 0)
                        shadow_live--;
                end
            end
        end
        rep.live = shadow_live[LIVE_OUT_W-1:0];
        return rep;
    endfunction

    // request side: hold the word until taken, then maybe idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_q[0].value, pending_q[0].key};
                s_tuser  <= pending_q[0].mode;
                void'(pending_q.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // prediction at the moment a request word is taken
    always @(posedge clk)
    begin
        table_req_t req;
        if (rst_n && s_tvalid && s_tready)
        begin
            req.mode  = s_tuser;
            req.key   = s_tdata[31:0];
            req.value = s_tdata[63:32];
            reply_q.push_back(table_apply(req));
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_seen != hold_req_seq)
        begin
            hold_seen <= hold_req_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    task automatic flag_mismatch(string what, table_reply_t want, table_reply_t got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t %s: exp found=%0b value=%h status=%0b live=%0d / got found=%0b value=%h status=%0b live=%0d",
                     $realtime, what, want.found, want.value, want.status, want.live,
                     got.found, got.value, got.status, got.live);
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        table_reply_t got;
        table_reply_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.found  = m_tuser[0];
                got.status = m_tuser[1];
                got.value  = m_tdata[31:0];
                got.live   = m_tdata[40:32];
                if (reply_q.size() == 0)
                begin
                    flag_mismatch("result word with nothing outstanding", '0, got);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got.found !== want.found)
                        flag_mismatch("found", want, got);
                    if (got.value !== want.value)
                        flag_mismatch("value_out", want, got);
                    if (got.status !== want.status)
                        flag_mismatch("status", want, got);
                    if (got.live !== want.live)
                        flag_mismatch("live_count", want, got);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic push_req(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
        table_req_t req;
        req.mode  = mode;
        req.key   = key;
        req.value = value;
        pending_q.push_back(req);
        if (mode == MODE_INSERT)
        begin
            known_keys.push_back(key);
            if (known_keys.size() > 48)
                void'(known_keys.pop_front());
        end
    endtask

    // mix of operations; keys often reused or crowded onto a few home slots
    task automatic push_random(int count);
        int          pick;
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                mode = MODE_INSERT;
            else if (pick < 75)
                mode = MODE_LOOKUP;
            else if (pick < 95)
                mode = MODE_REMOVE;
            else
                mode = MODE_UNUSED;
            if (known_keys.size() != 0 && $urandom_range(0, 99) < 55)
            begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            end
            else
            begin
                key = $urandom();
                if ($urandom_range(0, 1))
                    key[7:0] = $urandom_range(0, 1) ? 8'($urandom_range(0, 5))
                                                    : 8'($urandom_range(250, 255));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
                value = '0;
            else if (pick == 1)
                value = '1;
            else
                value = $urandom();
            push_req(mode, key, value);
        end
    endtask

    // sender pause: nothing queued, nothing offered, nothing owed
    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || reply_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] fill_keys [$];
        logic [31:0] key;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: misses on an empty table, collisions at slot 0, wrap
        // from slot 255, update, removal marks, reuse of a marked slot
        push_req(MODE_LOOKUP, 32'h0000_0000, 32'h0);
        push_req(MODE_REMOVE, 32'h0000_0000, 32'h0);
        push_req(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
        push_req(MODE_INSERT, 32'h0000_0100, 32'hFFFF_FFFF);
        push_req(MODE_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
        push_req(MODE_INSERT, 32'h0000_01FF, 32'hA5A5_A5A5);
        push_req(MODE_LOOKUP, 32'h0000_01FF, 32'h0);
        push_req(MODE_INSERT, 32'h0000_0100, 32'hDEAD_BEEF);
        push_req(MODE_LOOKUP, 32'h0000_0100, 32'h0);
        push_req(MODE_REMOVE, 32'h0000_0000, 32'h0);
        push_req(MODE_LOOKUP, 32'h0000_0100, 32'h0);
        push_req(MODE_LOOKUP, 32'h0000_01FF, 32'h0);
        push_req(MODE_LOOKUP, 32'h0000_0000, 32'h0);
        push_req(MODE_INSERT, 32'h0000_0200, 32'h0000_0001);
        push_req(MODE_LOOKUP, 32'h0000_0200, 32'h0);
        push_req(MODE_REMOVE, 32'h0000_0300, 32'h0);
        push_req(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        push_req(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0);
        push_req(MODE_INSERT, 32'h8000_0000, 32'h8000_0001);
        push_req(MODE_LOOKUP, 32'h0000_01FF, 32'h0);
        push_req(MODE_UNUSED, 32'h0000_0000, 32'h0);
        wait_drained();

        push_random(55);
        wait_drained();

        src_idle_pct = 50;
        push_random(55);
        wait_drained();

        // long hold-off on the result side with words still queued,
        // so the block backs up and refuses requests for a while
        src_idle_pct  = 0;
        snk_stall_pct = 50;
        hold_req_seq++;
        push_random(55);
        wait_drained();

        src_idle_pct  = 33;
        snk_stall_pct = 33;
        push_random(55);
        wait_drained();

        // fill past capacity: later inserts of new keys must be refused
        for (int i = 0; i < 270; i++)
        begin
            key = i * 32'h9E37_79B1;
            fill_keys.push_back(key);
            push_req(MODE_INSERT, key, $urandom());
        end
        for (int i = 0; i < 10; i++)
            push_req(MODE_INSERT, fill_keys[$urandom_range(0, 200)], $urandom());
        for (int i = 0; i < 15; i++)
            push_req(MODE_LOOKUP, $urandom_range(0, 1) ? fill_keys[$urandom_range(0, 269)]
                                                       : $urandom(), 32'h0);
        for (int i = 0; i < 220; i += 2)
            push_req(MODE_REMOVE, fill_keys[i], 32'h0);
        push_random(25);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && reply_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
